@@ hw/rtl/cfp_pkg.sv @@
`timescale 1ns / 1ps

package cfp_pkg;

	localparam int OUT_W   = 25;
	localparam int VEC_W   = 36;
	localparam int ANG_W   = 27;
	localparam int SAT_W   = 60;
	localparam int ATAN_N  = 24;
	localparam int ATAN_IW = 5;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_W      = 48;
	localparam int DIV_DIGITS = DIV_W / 2;
	localparam int DIV_R_W    = 7;
	localparam int DIV_K      = 125;

	localparam int SUM_W = 43;
	localparam int ACC_W = 60;
	localparam int P_W   = 71;
	localparam int INC_W = 41;

	localparam logic signed [OUT_W-1:0] DEG180 = 25'sd11796480;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic [P_W-1:0] INC_ROUND = 71'd128000;
	localparam logic [P_W-1:0] INC_LIMIT = (71'd256000 << 40) + INC_ROUND;
	localparam logic [INC_W-1:0] INC_CAP = 41'd1 << 40;
	localparam logic signed [ACC_W-1:0] BLEND_ROUND = 60'sd32768;

	localparam logic REG_BLEND_WEIGHT   = 1'b0;
	localparam logic REG_RATE_PER_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_DIV,
		ST_SUM,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_OUT
	} state_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:  v = 27'sd2949120;
			5'd1:  v = 27'sd1740967;
			5'd2:  v = 27'sd919879;
			5'd3:  v = 27'sd466945;
			5'd4:  v = 27'sd234379;
			5'd5:  v = 27'sd117304;
			5'd6:  v = 27'sd58666;
			5'd7:  v = 27'sd29335;
			5'd8:  v = 27'sd14668;
			5'd9:  v = 27'sd7334;
			5'd10: v = 27'sd3667;
			5'd11: v = 27'sd1833;
			5'd12: v = 27'sd917;
			5'd13: v = 27'sd458;
			5'd14: v = 27'sd229;
			5'd15: v = 27'sd115;
			5'd16: v = 27'sd57;
			5'd17: v = 27'sd29;
			5'd18: v = 27'sd14;
			5'd19: v = 27'sd7;
			5'd20: v = 27'sd4;
			5'd21: v = 27'sd2;
			5'd22: v = 27'sd1;
			default: v = 27'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat180(input logic signed [SAT_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_W'(DEG180))
			r = DEG180;
		else if (v < -SAT_W'(DEG180))
			r = -DEG180;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

@@ hw/rtl/cfp_mul.sv @@
`timescale 1ns / 1ps

module cfp_mul
	import cfp_pkg::*;
(
	input  logic                        clk,
	input  logic signed [MUL_A_W-1:0]   a,
	input  logic signed [MUL_B_W-1:0]   b,
	output logic signed [MUL_P_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ hw/rtl/cfp_div.sv @@
`timescale 1ns / 1ps

module cfp_div
	import cfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CW = $clog2(DIV_DIGITS + 1);

	logic               busy_q;
	logic [CW-1:0]      cnt_q;
	logic [DIV_W-1:0]   num_q;
	logic [DIV_R_W-1:0] rem_q;
	logic [DIV_R_W+1:0] trial;
	logic [DIV_R_W+1:0] rem_d;
	logic [1:0]         digit;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1 -: 2]};
		if (trial >= 9'(3 * DIV_K)) begin
			digit = 2'd3;
			rem_d = trial - 9'(3 * DIV_K);
		end else if (trial >= 9'(2 * DIV_K)) begin
			digit = 2'd2;
			rem_d = trial - 9'(2 * DIV_K);
		end else if (trial >= 9'(DIV_K)) begin
			digit = 2'd1;
			rem_d = trial - 9'(DIV_K);
		end else begin
			digit = 2'd0;
			rem_d = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_DIGITS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-3:0], digit};
			rem_q <= rem_d[DIV_R_W-1:0];
		end
	end

	assign done     = !busy_q;
	assign quotient = num_q;

endmodule

@@ hw/rtl/cfp_cordic.sv @@
`timescale 1ns / 1ps

module cfp_cordic
	import cfp_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      ax,
	input  logic signed [15:0]      az,
	output logic                    done,
	output logic signed [OUT_W-1:0] pitch
);

	localparam int CW = $clog2(STEPS + 1);

	logic                    busy_q;
	logic [CW-1:0]           cnt_q;
	logic                    zero_q;
	logic signed [VEC_W-1:0] vx_q;
	logic signed [VEC_W-1:0] vy_q;
	logic signed [ANG_W-1:0] ang_q;
	logic signed [VEC_W-1:0] vx_init;
	logic signed [VEC_W-1:0] vy_init;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic signed [ANG_W-1:0] step_ang;

	always_comb begin
		vx_init = VEC_W'(az) <<< 16;
		vy_init = VEC_W'(ax) <<< 16;
		if (az[15]) begin
			vx_init = -vx_init;
			vy_init = -vy_init;
		end
		dx       = vy_q >>> cnt_q;
		dy       = vx_q >>> cnt_q;
		step_ang = atan_q16(ATAN_IW'(cnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vx_q   <= vx_init;
			vy_q   <= vy_init;
			zero_q <= (ax == 16'sd0) && (az == 16'sd0);
			if (!az[15])
				ang_q <= '0;
			else if (!ax[15])
				ang_q <= ANG_W'(DEG180);
			else
				ang_q <= -ANG_W'(DEG180);
		end else if (busy_q) begin
			if (!vy_q[VEC_W-1]) begin
				vx_q  <= vx_q + dx;
				vy_q  <= vy_q - dy;
				ang_q <= ang_q + step_ang;
			end else begin
				vx_q  <= vx_q - dx;
				vy_q  <= vy_q + dy;
				ang_q <= ang_q - step_ang;
			end
		end
	end

	assign done  = !busy_q;
	assign pitch = zero_q ? '0 : sat180(SAT_W'(ang_q));

endmodule

@@ hw/rtl/complementary_filter_pitch.sv @@
`timescale 1ns / 1ps

// Complementary-filter pitch estimator.
// s_axis carries one IMU sample per request; m_axis carries one result per
// sample: the filtered pitch and the accelerometer-only pitch, both Q9.16
// degrees. Registers blend_weight (index 0) and rate_per_count (index 1)
// are written through cfg_we / cfg_index / cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce.
// The path from an accepted sample to m_axis_tvalid runs through the
// 24-step radix-4 divide by 125 that scales the gyro increment; the CORDIC
// (CORDIC_STEPS iterations) runs alongside it, and one shared multiplier
// serves all six products in turn. s_axis_tready is high only while no
// sample is in work, so the last result must reach the output register first.
// A finished result sits in the output register; if m_axis_tready is low
// the next sample is still taken and its result holds until the register
// frees.
// Reset clears the last timestamp and the pitch to zero and restores the
// register reset values.
module complementary_filter_pitch
	import cfp_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // accel_x_raw, accel_z_raw, gyro_y_raw, timestamp_ms
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // pitch_deg, accel_pitch_deg, zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [16:0] alpha_q;
	logic [23:0] rate_q;
	logic [31:0] prev_q;
	logic signed [OUT_W-1:0] pitch_q;

	logic [31:0]             dt_q;
	logic                    gy_neg_q;
	logic [16:0]             gy_abs_q;
	logic [18:0]             mag_hi_q;
	logic [51:0]             plo_q;
	logic                    cap_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [OUT_W-1:0] res_q;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_pitch_q;
	logic signed [OUT_W-1:0] out_accel_q;

	logic accept;
	logic out_load;
	logic signed [15:0] in_ax, in_az, in_gy;
	logic [31:0]        in_ts;
	logic signed [16:0] gy_ext;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	logic cordic_start;
	logic cordic_done;
	logic div_start;
	logic div_done;
	logic signed [OUT_W-1:0] accel_pitch;
	logic [DIV_W-1:0]        div_quot;

	logic [P_W-1:0]          p_full;
	logic [P_W-1:0]          p_round;
	logic [16:0]             alpha_eff;
	logic [16:0]             alpha_rest;
	logic [INC_W-1:0]        inc_mag;
	logic signed [SUM_W-1:0] inc_s;
	logic signed [SUM_W-1:0] sum_d;
	logic signed [ACC_W-1:0] total;
	logic signed [ACC_W-1:0] rounded;

	assign in_ax  = s_axis_tdata[15:0];
	assign in_az  = s_axis_tdata[31:16];
	assign in_gy  = s_axis_tdata[47:32];
	assign in_ts  = s_axis_tdata[79:48];
	assign gy_ext = 17'(in_gy);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign alpha_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_rest = ALPHA_ONE - alpha_eff;

	assign p_full  = P_W'(plo_q) + {prod_q[50:0], 20'd0};
	assign p_round = p_full + INC_ROUND;
	assign inc_mag = cap_q ? INC_CAP : div_quot[INC_W-1:0];
	assign inc_s   = $signed({2'd0, inc_mag});
	assign sum_d   = SUM_W'(pitch_q) + (gy_neg_q ? -inc_s : inc_s);
	assign total   = acc_q + ACC_W'(prod_q);
	assign rounded = (total + BLEND_ROUND) >>> 16;

	cfp_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start),
		.ax    (in_ax),
		.az    (in_az),
		.done  (cordic_done),
		.pitch (accel_pitch)
	);

	cfp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(p_round[58:11]),
		.done    (div_done),
		.quotient(div_quot)
	);

	cfp_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		cordic_start = 1'b0;
		div_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cordic_start = 1'b1;
					state_d      = ST_MAG;
				end
			end
			ST_MAG: begin
				mul_a   = $signed({9'd0, rate_q});
				mul_b   = $signed({8'd0, gy_abs_q});
				state_d = ST_P0;
			end
			ST_P0: begin
				mul_a   = $signed({1'b0, dt_q});
				mul_b   = $signed({5'd0, prod_q[19:0]});
				state_d = ST_P1;
			end
			ST_P1: begin
				mul_a   = $signed({1'b0, dt_q});
				mul_b   = $signed({6'd0, mag_hi_q});
				state_d = ST_P2;
			end
			ST_P2: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_B0;
			end
			ST_B0: begin
				mul_a = $signed({12'd0, sum_q[20:0]});
				mul_b = $signed({8'd0, alpha_eff});
				if (cordic_done)
					state_d = ST_B1;
			end
			ST_B1: begin
				mul_a   = MUL_A_W'($signed(sum_q[SUM_W-1:21]));
				mul_b   = $signed({8'd0, alpha_eff});
				state_d = ST_B2;
			end
			ST_B2: begin
				mul_a   = MUL_A_W'(accel_pitch);
				mul_b   = $signed({8'd0, alpha_rest});
				state_d = ST_B3;
			end
			ST_B3: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= 17'd64225;
			rate_q      <= 24'd128070;
			prev_q      <= '0;
			pitch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BLEND_WEIGHT:   alpha_q <= cfg_wdata[16:0];
					REG_RATE_PER_COUNT: rate_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept)
				prev_q <= in_ts;
			if (out_load) begin
				pitch_q     <= res_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q     <= in_ts - prev_q;
			gy_neg_q <= in_gy[15];
			gy_abs_q <= in_gy[15] ? 17'(-gy_ext) : 17'(gy_ext);
		end
		case (state_q)
			ST_P0: mag_hi_q <= prod_q[38:20];
			ST_P1: plo_q    <= prod_q[51:0];
			ST_P2: cap_q    <= (p_full >= INC_LIMIT);
			ST_SUM: sum_q   <= sum_d;
			ST_B1: acc_q    <= ACC_W'(prod_q);
			ST_B2: acc_q    <= acc_q + (ACC_W'(prod_q) <<< 21);
			ST_B3: res_q    <= sat180(SAT_W'(rounded));
			default: ;
		endcase
		if (out_load) begin
			out_pitch_q <= res_q;
			out_accel_q <= accel_pitch;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_accel_q, out_pitch_q};

endmodule

@@ hw/rtl/cfp_checker.sv @@
`timescale 1ns / 1ps

module cfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a request is in work");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a request in work");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[24:0]) <= 25'sd11796480)
			&& ($signed(m_axis_tdata[24:0]) >= -25'sd11796480)
			&& ($signed(m_axis_tdata[49:25]) <= 25'sd11796480)
			&& ($signed(m_axis_tdata[49:25]) >= -25'sd11796480)
			&& (m_axis_tdata[55:50] == 6'd0))
		else $error("result outside the saturation range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind complementary_filter_pitch cfp_checker u_cfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import cfp_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic signed [OUT_W-1:0] accel;
		logic signed [OUT_W-1:0] pitch;
	} tilt_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;  // accel_x_raw, accel_z_raw, gyro_y_raw, timestamp_ms
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;       // pitch_deg, accel_pitch_deg, zero pad
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_BLEND_WEIGHT;
	logic [23:0] cfg_wdata = '0;

	logic [79:0] sample_q[$];
	tilt_t       tilt_q[$];

	logic [16:0] alpha_cfg = 17'd64225;
	logic [23:0] rate_cfg = 24'd128070;
	logic [31:0] last_time = '0;
	longint      pitch_acc = 0;

	int atan_step [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	int samples_sent = 0;
	int results_seen = 0;
	int fail_count = 0;
	int max_gap = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_done;
	int hold_left;
	int burst_left;
	int gap_left;
	int idle_cycles;

	complementary_filter_pitch #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clamp_half_turn(input longint v);
		if (v > HALF_TURN)
			return HALF_TURN;
		if (v < -HALF_TURN)
			return -HALF_TURN;
		return v;
	endfunction

	function automatic tilt_t filter_step(input logic [79:0] smp);
		logic signed [15:0] ax, az, gy;
		logic [31:0] now, dt;
		longint vx, vy, ang, dx, dy, acc, g, inc, a, sum, total, res;
		logic [95:0] mag, prod, inc_mag;
		tilt_t r;
		ax = smp[15:0];
		az = smp[31:16];
		gy = smp[47:32];
		now = smp[79:48];
		dt = now - last_time;
		last_time = now;

		if (ax == 0 && az == 0) begin
			acc = 0;
		end else begin
			vx = longint'(az) * 65536;
			vy = longint'(ax) * 65536;
			ang = 0;
			if (az < 0) begin
				ang = (ax >= 0) ? HALF_TURN : -HALF_TURN;
				vx = -vx;
				vy = -vy;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy >= 0) begin
					vx = vx + dx;
					vy = vy - dy;
					ang = ang + atan_step[i];
				end else begin
					vx = vx - dx;
					vy = vy + dy;
					ang = ang - atan_step[i];
				end
			end
			acc = clamp_half_turn(ang);
		end

		g = longint'(gy);
		if (g < 0)
			g = -g;
		mag = 96'(g) * 96'(rate_cfg);
		prod = mag * 96'(dt);
		inc_mag = prod / 96'd256000 + (((prod % 96'd256000) >= 96'd128000) ? 96'd1 : 96'd0);
		if (inc_mag > (96'd1 << 40))
			inc_mag = 96'd1 << 40;
		inc = longint'(inc_mag[63:0]);
		if (gy < 0)
			inc = -inc;

		a = (alpha_cfg > 17'd65536) ? 65536 : longint'(alpha_cfg);
		sum = pitch_acc + inc;
		total = a * sum + (65536 - a) * acc;
		res = clamp_half_turn((total + 32768) >>> 16);
		pitch_acc = res;

		r.pitch = res[OUT_W-1:0];
		r.accel = acc[OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [79:0] pack_sample(input logic [15:0] ax, input logic [15:0] az,
			input logic [15:0] gy, input logic [31:0] ts);
		return {ts, gy, az, ax};
	endfunction

	function automatic logic [79:0] rand_sample(input logic [31:0] prev_ts);
		logic [15:0] ax, az, gy;
		logic [31:0] ts;
		int sel;
		ax = 16'($urandom);
		az = 16'($urandom);
		gy = 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			ax = '0;
			az = '0;
		end else if (sel < 10) begin
			ax = '0;
		end else if (sel < 15) begin
			az = '0;
		end else if (sel < 20) begin
			ax = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			az = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		end else if (sel < 25) begin
			gy = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		end
		sel = $urandom_range(0, 99);
		if (sel < 85)
			ts = prev_ts + 32'($urandom_range(1, 25));
		else if (sel < 90)
			ts = prev_ts;
		else
			ts = $urandom;
		return pack_sample(ax, az, gy, ts);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tilt_q.push_back(filter_step(s_axis_tdata));
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		tilt_t want;
		tilt_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			got.pitch = m_axis_tdata[OUT_W-1:0];
			got.accel = m_axis_tdata[2*OUT_W-1:OUT_W];
			if (tilt_q.size() == 0) begin
				$error("result with no request pending: pitch_deg %0d accel_pitch_deg %0d",
					got.pitch, got.accel);
				fail_count++;
			end else begin
				want = tilt_q.pop_front();
				if (got.pitch !== want.pitch) begin
					$error("pitch_deg expected %0d actual %0d", want.pitch, got.pitch);
					fail_count++;
				end
				if (got.accel !== want.accel) begin
					$error("accel_pitch_deg expected %0d actual %0d", want.accel, got.accel);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BLEND_WEIGHT)
			alpha_cfg = val[16:0];
		else
			rate_cfg = val;
	endtask

	task automatic send(input logic [79:0] smp);
		sample_q.push_back(smp);
		samples_sent++;
	endtask

	task automatic drain;
		while (results_seen != samples_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [23:0] alpha, input logic [23:0] rate,
			input int stall, input int gap, input int count, input logic pressure);
		logic [31:0] ts;
		logic [79:0] smp;
		write_reg(REG_BLEND_WEIGHT, alpha);
		write_reg(REG_RATE_PER_COUNT, rate);
		stall_pct <= stall;
		max_gap <= gap;
		if (pressure)
			hold_go <= 1'b1;
		@(posedge clk);
		ts = last_time;
		for (int k = 0; k < count; k++) begin
			smp = rand_sample(ts);
			ts = smp[79:48];
			send(smp);
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, directed corners
		send(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd0));
		send(pack_sample(16'h7fff, 16'h0000, 16'h7fff, 32'd10));
		send(pack_sample(16'h8000, 16'h0000, 16'h8000, 32'd20));
		send(pack_sample(16'h0000, 16'h7fff, 16'h0001, 32'd30));
		send(pack_sample(16'h0000, 16'h8000, 16'hffff, 32'd40));
		send(pack_sample(16'hffff, 16'h8000, 16'h0000, 32'd41));
		send(pack_sample(16'h7fff, 16'h7fff, 16'h7fff, 32'd50));
		send(pack_sample(16'h8000, 16'h8000, 16'h8000, 32'd60));
		send(pack_sample(16'h0001, 16'hffff, 16'h1234, 32'd61));
		send(pack_sample(16'hffff, 16'h0001, 16'hedcb, 32'd62));
		send(pack_sample(16'h0001, 16'h8000, 16'h0000, 32'd63));
		send(pack_sample(16'hffff, 16'h7fff, 16'h0000, 32'd64));
		send(pack_sample(16'h4000, 16'h4000, 16'h8000, 32'hffff_ffff));
		send(pack_sample(16'h2000, 16'hc000, 16'h7fff, 32'd5));
		send(pack_sample(16'h2000, 16'hc000, 16'h7fff, 32'd5));
		send(pack_sample(16'haaaa, 16'h5555, 16'h7fff, 32'h8000_0000));
		send(pack_sample(16'h5555, 16'haaaa, 16'h8000, 32'h7fff_ffff));
		send(pack_sample(16'h0000, 16'h0000, 16'h8000, 32'h0000_0000));
		drain();

		run_phase(24'd65536, 24'hffffff, 30, 4, 60, 1'b0);
		run_phase(24'd0, 24'd0, 0, 0, 50, 1'b1);
		run_phase(24'hffffff, 24'($urandom_range(0, 24'hffffff)), 60, 60, 50, 1'b0);
		run_phase(24'd65537, 24'hffffff, 10, 0, 40, 1'b0);
		for (int p = 0; p < 5; p++)
			run_phase(24'($urandom_range(0, 131071)), 24'($urandom), $urandom_range(0, 80),
				$urandom_range(0, 60), 40, 1'b0);
		run_phase(24'd64225, 24'd128070, 20, 10, 30, 1'b0);

		if (tilt_q.size() != 0) begin
			$error("%0d expected results never arrived", tilt_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
